>>> rtl/sprite_bounding_box_grow_macros.svh
// Assertion macros shared by the sprite bounding box grower RTL.
`ifndef SPRITE_BOUNDING_BOX_GROW_MACROS_SVH
`define SPRITE_BOUNDING_BOX_GROW_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SBBG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbbg: property violated");
// condition must never be seen outside reset
`define SBBG_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sbbg: forbidden condition seen");
`else
`define SBBG_ASSERT(lbl, prop)
`define SBBG_NEVER(lbl, expr)
`endif
`endif

>>> rtl/sbbg_pkg.sv
// Types, constants and microprogram of the sprite bounding box grower.
package sbbg_pkg;

    localparam int COORD_W = 8;
    localparam int ALPHA_W = 8;
    localparam int CFG_W   = 9;
    localparam int BOXH_W  = 9;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {DIR_UP, DIR_DN, DIR_LF, DIR_RT} dir_t;
    typedef enum logic [1:0] {U_CLR, U_TEST, U_SCAN, U_LOOP} uop_t;

    localparam int UPC_W    = 4;
    localparam int PROG_LEN = 10;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t S_PASS    = 4'd0;
    localparam upc_t S_UP_TEST = 4'd1;
    localparam upc_t S_UP_SCAN = 4'd2;
    localparam upc_t S_DN_TEST = 4'd3;
    localparam upc_t S_DN_SCAN = 4'd4;
    localparam upc_t S_LF_TEST = 4'd5;
    localparam upc_t S_LF_SCAN = 4'd6;
    localparam upc_t S_RT_TEST = 4'd7;
    localparam upc_t S_RT_SCAN = 4'd8;
    localparam upc_t S_LOOP    = 4'd9;

    // TEST: fall through and start a scan, or jump to target when the edge test fails.
    // SCAN: hold until done; a hit grows the box and jumps to target, a miss falls through.
    // LOOP: jump to target when the pass grew, else the search is over.
    typedef struct packed {
        uop_t op;
        dir_t dir;
        upc_t target;
    } uword_t;

    typedef struct packed {
        logic run;
        uop_t op;
        dir_t dir;
        logic finish;
    } seq_ctrl_t;

    typedef struct packed {
        logic cond;
        logic scan_done;
        logic scan_hit;
        logic grew;
        logic outside;
    } dp_stat_t;

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        unique case (pc)
            S_PASS:    w = '{op: U_CLR,  dir: DIR_UP, target: S_PASS};
            S_UP_TEST: w = '{op: U_TEST, dir: DIR_UP, target: S_DN_TEST};
            S_UP_SCAN: w = '{op: U_SCAN, dir: DIR_UP, target: S_UP_TEST};
            S_DN_TEST: w = '{op: U_TEST, dir: DIR_DN, target: S_LF_TEST};
            S_DN_SCAN: w = '{op: U_SCAN, dir: DIR_DN, target: S_DN_TEST};
            S_LF_TEST: w = '{op: U_TEST, dir: DIR_LF, target: S_RT_TEST};
            S_LF_SCAN: w = '{op: U_SCAN, dir: DIR_LF, target: S_LF_TEST};
            S_RT_TEST: w = '{op: U_TEST, dir: DIR_RT, target: S_LOOP};
            S_RT_SCAN: w = '{op: U_SCAN, dir: DIR_RT, target: S_RT_TEST};
            S_LOOP:    w = '{op: U_LOOP, dir: DIR_UP, target: S_PASS};
            default:   w = '{op: U_LOOP, dir: DIR_UP, target: S_PASS};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/sprite_bounding_box_grow.sv
// Sprite bounding box grower: top level with config registers and result register.
//
// Channel   Direction  Transfer fields
// s_*       in         tuser: operation; tdata: pos_x, pos_y, alpha
// m_*       out        tuser: seed_outside; tdata: box_left, box_top, box_width, box_height
// APB       in/out     image_width (0x0), image_height (0x4)
//
// Pixel loads transfer at one per cycle whenever no search runs.
// A start transfer runs the microprogram over the single-port bitmap: each row or
// column scan takes a test step, reads its pixels in turn and waits out the read
// latency; a pass adds two steps. An outside seed skips the program.
// No input is taken during a search; a finished result waits in the output register
// while loads continue, and a search ending while it is full holds until it is taken.
// Reset needs no clearing pass: bitmap contents are valid only once written.
`include "sprite_bounding_box_grow_macros.svh"
module sprite_bounding_box_grow #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // pos_x[7:0], pos_y[15:8], alpha[23:16]
    input  logic [0:0]  s_tuser,    // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // box_left[7:0], box_top[15:8], box_width[23:16],
                                    // box_height[32:24], zero[39:33]
    output logic [0:0]  m_tuser     // seed_outside[0]
);
    import sbbg_pkg::*;

    logic [CFG_W-1:0]   image_width_reg, image_width_next;
    logic [CFG_W-1:0]   image_height_reg, image_height_next;
    logic               cfg_we;
    logic               s_acc, load, start, out_free;
    logic               out_valid_reg, out_valid_next;
    logic [39:0]        out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;
    seq_ctrl_t          ctrl;
    dp_stat_t           stat;
    logic [COORD_W-1:0] box_left, box_top, box_width;
    logic [BOXH_W-1:0]  box_height;
    logic               seed_outside;

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_we)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  image_width_next  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_next = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W'(256);
            image_height_reg <= CFG_W'(256);
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // input stream
    assign s_tready = !ctrl.run;
    assign s_acc    = s_tvalid && s_tready;
    assign load     = s_acc && (s_tuser[0] == OP_LOAD);
    assign start    = s_acc && (s_tuser[0] == OP_START);
    assign out_free = !out_valid_reg || m_tready;

    sbbg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    sbbg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .load         (load),
        .start        (start),
        .pos_x        (s_tdata[7:0]),
        .pos_y        (s_tdata[15:8]),
        .alpha        (s_tdata[23:16]),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .stat         (stat),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_width    (box_width),
        .box_height   (box_height),
        .seed_outside (seed_outside)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {7'b0, box_height, box_width, box_top, box_left};
            out_user_next  = seed_outside;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

endmodule

>>> rtl/sbbg_ram.sv
// Generic single-port RAM with registered read.
module sbbg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> rtl/sbbg_seq.sv
// Microcode sequencer: step counter, program fetch and conditional jumps.
`include "sprite_bounding_box_grow_macros.svh"
module sbbg_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 out_free,
    input  sbbg_pkg::dp_stat_t   stat,
    output sbbg_pkg::seq_ctrl_t  ctrl
);
    import sbbg_pkg::*;

    logic   run_reg, run_next;
    upc_t   pc_reg, pc_next;
    uword_t uw;
    logic   finish_req;

    assign uw = ucode(pc_reg);

    // an outside seed skips the program altogether
    assign finish_req = run_reg && (stat.outside || (uw.op == U_LOOP && !stat.grew));

    assign ctrl.run    = run_reg;
    assign ctrl.op     = uw.op;
    assign ctrl.dir    = uw.dir;
    assign ctrl.finish = finish_req && out_free;

    always_comb
    begin
        run_next = run_reg;
        pc_next  = pc_reg;
        if (start)
        begin
            run_next = 1'b1;
            pc_next  = S_PASS;
        end
        else if (run_reg)
        begin
            if (finish_req)
            begin
                if (out_free)
                begin
                    run_next = 1'b0;
                end
            end
            else
            begin
                unique case (uw.op)
                    U_CLR:  pc_next = pc_reg + 1'b1;
                    U_TEST: pc_next = stat.cond ? pc_reg + 1'b1 : uw.target;
                    U_SCAN:
                    begin
                        if (stat.scan_done)
                        begin
                            pc_next = stat.scan_hit ? uw.target : pc_reg + 1'b1;
                        end
                    end
                    U_LOOP: pc_next = uw.target;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= S_PASS;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
        end
    end

    `SBBG_NEVER(a_no_start_while_busy, run_reg && start)
    `SBBG_ASSERT(a_pc_in_program, run_reg |-> (pc_reg < UPC_W'(PROG_LEN)))
    `SBBG_ASSERT(a_finish_ends_run, ctrl.finish |=> !run_reg)

endmodule

>>> rtl/sbbg_dp.sv
// Datapath: box registers, edge tests, pixel scan engine and the opaque bitmap.
`include "sprite_bounding_box_grow_macros.svh"
module sbbg_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sbbg_pkg::seq_ctrl_t                  ctrl,
    input  logic                                 load,
    input  logic                                 start,
    input  logic [sbbg_pkg::COORD_W-1:0]         pos_x,
    input  logic [sbbg_pkg::COORD_W-1:0]         pos_y,
    input  logic [sbbg_pkg::ALPHA_W-1:0]         alpha,
    input  logic [sbbg_pkg::CFG_W-1:0]           image_width,
    input  logic [sbbg_pkg::CFG_W-1:0]           image_height,
    output sbbg_pkg::dp_stat_t                   stat,
    output logic [sbbg_pkg::COORD_W-1:0]         box_left,
    output logic [sbbg_pkg::COORD_W-1:0]         box_top,
    output logic [sbbg_pkg::COORD_W-1:0]         box_width,
    output logic [sbbg_pkg::BOXH_W-1:0]          box_height,
    output logic                                 seed_outside
);
    import sbbg_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = XW + 1;
    localparam int HW    = YW + 1;
    localparam int WSUMW = WW + 1;
    localparam int HSUMW = HW + 1;
    localparam int CWW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int CHW   = (HW > CFG_W) ? HW : CFG_W;
    localparam int CNTW  = (XW > YW) ? XW : YW;
    localparam int AW    = XW + YW;

    logic [XW-1:0]   l_reg, l_next, bw_reg, bw_next, sx_reg, sx_next;
    logic [YW-1:0]   t_reg, t_next, sy_reg, sy_next;
    logic [HW-1:0]   bh_reg, bh_next, h_reg, h_next;
    logic [WW-1:0]   w_reg, w_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            outside_reg, outside_next;
    logic            grew_reg, grew_next;
    logic            issue_reg, issue_next;
    logic            rdpend_reg, rdpend_next;

    logic [CWW-1:0]  wcfg, w_clamp;
    logic [CHW-1:0]  hcfg, h_clamp;
    logic            seed_out, load_ok;
    logic            active, cond, rd_en, hit_now, done_miss;
    logic [YW-1:0]   row_up, row_dn;
    logic [XW-1:0]   col_lf, col_rt;
    logic [CNTW-1:0] cnt_row, cnt_col;
    logic            ram_we, ram_rdata;
    logic [AW-1:0]   ram_addr;

    // oversized register values act as the storage size
    assign wcfg    = CWW'(image_width);
    assign hcfg    = CHW'(image_height);
    assign w_clamp = (wcfg > CWW'(MAX_WIDTH)) ? CWW'(MAX_WIDTH) : wcfg;
    assign h_clamp = (hcfg > CHW'(MAX_HEIGHT)) ? CHW'(MAX_HEIGHT) : hcfg;
    assign seed_out = (CWW'(pos_x) >= w_clamp) || (CHW'(pos_y) >= h_clamp);
    assign load_ok  = load && (CWW'(pos_x) < CWW'(MAX_WIDTH))
                           && (CHW'(pos_y) < CHW'(MAX_HEIGHT));

    assign active = ctrl.run && !outside_reg;

    always_comb
    begin
        unique case (ctrl.dir)
            DIR_UP: cond = (t_reg != '0);
            DIR_DN: cond = (HSUMW'(t_reg) + HSUMW'(bh_reg)) < HSUMW'(h_reg);
            DIR_LF: cond = (l_reg != '0) && (bh_reg != '0);
            DIR_RT: cond = ((WSUMW'(l_reg) + WSUMW'(bw_reg) + WSUMW'(1)) < WSUMW'(w_reg))
                           && (bh_reg != '0);
        endcase
    end

    assign row_up  = t_reg - 1'b1;
    assign row_dn  = YW'(HW'(t_reg) + bh_reg);
    assign col_lf  = l_reg - 1'b1;
    assign col_rt  = XW'(WW'(l_reg) + WW'(bw_reg) + WW'(1));
    assign cnt_row = CNTW'(bw_reg);
    assign cnt_col = CNTW'(bh_reg - 1'b1);

    // read data is valid in the cycle after the read is issued
    assign rd_en     = active && (ctrl.op == U_SCAN) && issue_reg;
    assign hit_now   = rdpend_reg && ram_rdata;
    assign done_miss = !issue_reg && rdpend_reg && !ram_rdata;

    assign stat.cond      = cond;
    assign stat.scan_done = hit_now || done_miss;
    assign stat.scan_hit  = hit_now;
    assign stat.grew      = grew_reg;
    assign stat.outside   = outside_reg;

    always_comb
    begin
        l_next       = l_reg;
        t_next       = t_reg;
        bw_next      = bw_reg;
        bh_next      = bh_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        cnt_next     = cnt_reg;
        outside_next = outside_reg;
        grew_next    = grew_reg;
        issue_next   = issue_reg;
        rdpend_next  = rdpend_reg;
        if (start)
        begin
            l_next       = XW'(pos_x);
            t_next       = YW'(pos_y);
            bw_next      = '0;
            bh_next      = '0;
            w_next       = WW'(w_clamp);
            h_next       = HW'(h_clamp);
            outside_next = seed_out;
            grew_next    = 1'b0;
            issue_next   = 1'b0;
            rdpend_next  = 1'b0;
        end
        else if (active)
        begin
            unique case (ctrl.op)
                U_CLR: grew_next = 1'b0;
                U_TEST:
                begin
                    if (cond)
                    begin
                        issue_next  = 1'b1;
                        rdpend_next = 1'b0;
                        unique case (ctrl.dir)
                            DIR_UP:
                            begin
                                sx_next  = l_reg;
                                sy_next  = row_up;
                                cnt_next = cnt_row;
                            end
                            DIR_DN:
                            begin
                                sx_next  = l_reg;
                                sy_next  = row_dn;
                                cnt_next = cnt_row;
                            end
                            DIR_LF:
                            begin
                                sx_next  = col_lf;
                                sy_next  = t_reg;
                                cnt_next = cnt_col;
                            end
                            DIR_RT:
                            begin
                                sx_next  = col_rt;
                                sy_next  = t_reg;
                                cnt_next = cnt_col;
                            end
                        endcase
                    end
                end
                U_SCAN:
                begin
                    if (hit_now || done_miss)
                    begin
                        issue_next  = 1'b0;
                        rdpend_next = 1'b0;
                        if (hit_now)
                        begin
                            grew_next = 1'b1;
                            unique case (ctrl.dir)
                                DIR_UP:
                                begin
                                    t_next  = t_reg - 1'b1;
                                    bh_next = bh_reg + 1'b1;
                                end
                                DIR_DN: bh_next = bh_reg + 1'b1;
                                DIR_LF:
                                begin
                                    l_next  = l_reg - 1'b1;
                                    bw_next = bw_reg + 1'b1;
                                end
                                DIR_RT: bw_next = bw_reg + 1'b1;
                            endcase
                        end
                    end
                    else
                    begin
                        rdpend_next = issue_reg;
                        if (issue_reg)
                        begin
                            if (ctrl.dir == DIR_UP || ctrl.dir == DIR_DN)
                            begin
                                sx_next = sx_reg + 1'b1;
                            end
                            else
                            begin
                                sy_next = sy_reg + 1'b1;
                            end
                            cnt_next = cnt_reg - 1'b1;
                            if (cnt_reg == '0)
                            begin
                                issue_next = 1'b0;
                            end
                        end
                    end
                end
                U_LOOP: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg <= 1'b0;
            grew_reg    <= 1'b0;
            issue_reg   <= 1'b0;
            rdpend_reg  <= 1'b0;
        end
        else
        begin
            outside_reg <= outside_next;
            grew_reg    <= grew_next;
            issue_reg   <= issue_next;
            rdpend_reg  <= rdpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg   <= l_next;
        t_reg   <= t_next;
        bw_reg  <= bw_next;
        bh_reg  <= bh_next;
        w_reg   <= w_next;
        h_reg   <= h_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        cnt_reg <= cnt_next;
    end

    // loads only arrive while no search runs, so the port is never contended
    assign ram_we   = load_ok;
    assign ram_addr = ram_we ? {YW'(pos_y), XW'(pos_x)} : {sy_reg, sx_reg};

    sbbg_ram #(
        .WIDTH (1),
        .DEPTH (2 ** AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .re    (rd_en),
        .addr  (ram_addr),
        .wdata (alpha != '0),
        .rdata (ram_rdata)
    );

    assign box_left     = outside_reg ? '0 : COORD_W'(l_reg);
    assign box_top      = outside_reg ? '0 : COORD_W'(t_reg);
    assign box_width    = outside_reg ? '0 : COORD_W'(bw_reg);
    assign box_height   = outside_reg ? '0 : BOXH_W'(bh_reg);
    assign seed_outside = outside_reg;

    `SBBG_ASSERT(a_read_in_image, rd_en |-> (WW'(sx_reg) < w_reg) && (HW'(sy_reg) < h_reg))
    `SBBG_ASSERT(a_box_in_image, active |-> ((WSUMW'(l_reg) + WSUMW'(bw_reg)) < WSUMW'(w_reg)) && ((HSUMW'(t_reg) + HSUMW'(bh_reg)) <= HSUMW'(h_reg)))
    `SBBG_ASSERT(a_hit_sets_grew, (active && ctrl.op == U_SCAN && hit_now) |=> grew_reg)

endmodule

>>> sim/tb_sprite_bounding_box_grow.sv
// Self-checking testbench for the sprite bounding box grower: pixel loads, seed searches, APB setup.
module tb_sprite_bounding_box_grow;
    import sbbg_pkg::*;

    localparam int MAP_SIDE      = 256;
    localparam int ITEM_TARGET   = 1350;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        logic       op;
        logic [7:0] alpha;
        logic [7:0] y;
        logic [7:0] x;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] top;
        logic [7:0] width;
        logic [8:0] height;
        logic       outside;
    } box_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // pos_x[7:0], pos_y[15:8], alpha[23:16]
    logic [0:0]  s_tuser  = '0;    // operation[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // box_left[7:0], box_top[15:8], box_width[23:16],
                                   // box_height[32:24], zero[39:33]
    logic [0:0]  m_tuser;          // seed_outside[0]

    pixel_item_t pending_items[$];
    box_t        expected_boxes[$];
    bit          pixel_map [0:MAP_SIDE*MAP_SIDE-1];
    bit          sprite_plan [0:MAP_SIDE*MAP_SIDE-1];
    logic [8:0]  cfg_width  = 9'd256;
    logic [8:0]  cfg_height = 9'd256;

    pixel_item_t cur_item;
    box_t        got_box;
    box_t        want_box;
    int items_pushed   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int rx_left        = 0;
    int rx_mode        = 0;
    int hold_left      = 0;

    sprite_bounding_box_grow u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // register values above the storage size behave as the storage size
    function automatic int visible_dim(input logic [8:0] v);
        return (v > MAP_SIDE) ? MAP_SIDE : int'(v);
    endfunction

    function automatic bit opaque_at(input int x, input int y);
        if (x >= MAP_SIDE || y >= MAP_SIDE)
            return 1'b0;
        return pixel_map[y*MAP_SIDE + x];
    endfunction

    function automatic bit row_opaque(input int y, input int l, input int bw);
        int i;
        for (i = 0; i <= bw; i++)
            if (opaque_at(l + i, y))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit col_opaque(input int x, input int t, input int bh);
        int i;
        for (i = 0; i < bh; i++)
            if (opaque_at(x, t + i))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic box_t grow_box(input int sx, input int sy);
        box_t b;
        int w;
        int h;
        int l;
        int t;
        int bw;
        int bh;
        bit grew;
        b = '0;
        w = visible_dim(cfg_width);
        h = visible_dim(cfg_height);
        if (sx >= w || sy >= h)
        begin
            b.outside = 1'b1;
            return b;
        end
        l = sx;
        t = sy;
        bw = 0;
        bh = 0;
        grew = 1'b1;
        // up, down, left, right; repeat until a whole pass adds nothing
        while (grew)
        begin
            grew = 1'b0;
            while (t > 0 && row_opaque(t - 1, l, bw))
            begin
                t = t - 1;
                bh = bh + 1;
                grew = 1'b1;
            end
            while (t + bh < h && row_opaque(t + bh, l, bw))
            begin
                bh = bh + 1;
                grew = 1'b1;
            end
            while (l > 0 && col_opaque(l - 1, t, bh))
            begin
                l = l - 1;
                bw = bw + 1;
                grew = 1'b1;
            end
            while (l + bw + 1 < w && col_opaque(l + bw + 1, t, bh))
            begin
                bw = bw + 1;
                grew = 1'b1;
            end
        end
        b.left   = l;
        b.top    = t;
        b.width  = bw;
        b.height = bh;
        return b;
    endfunction

    function automatic void take_pixel_item(input pixel_item_t it);
        if (it.op == OP_LOAD)
            pixel_map[{it.y, it.x}] = (it.alpha != 8'd0);
        else
            expected_boxes.push_back(grow_box(it.x, it.y));
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                take_pixel_item(cur_item);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_item.alpha, cur_item.y, cur_item.x};
                    s_tuser  <= cur_item.op;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result checker and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got_box.left    = m_tdata[7:0];
                got_box.top     = m_tdata[15:8];
                got_box.width   = m_tdata[23:16];
                got_box.height  = m_tdata[32:24];
                got_box.outside = m_tuser[0];
                if (expected_boxes.size() == 0)
                begin
                    $error("result transfer with no search outstanding: left %0d top %0d",
                           got_box.left, got_box.top);
                    error_count++;
                end
                else
                begin
                    want_box = expected_boxes.pop_front();
                    check_field("box_left", want_box.left, got_box.left);
                    check_field("box_top", want_box.top, got_box.top);
                    check_field("box_width", want_box.width, got_box.width);
                    check_field("box_height", want_box.height, got_box.height);
                    check_field("seed_outside", want_box.outside, got_box.outside);
                end
                // long back-pressure so the block fills up and stalls its input
                if (results_seen == 5 || results_seen == 40)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(20, 200);
                end
                else
                    rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_item(input logic op, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] alpha);
        pixel_item_t it;
        it.op    = op;
        it.x     = x;
        it.y     = y;
        it.alpha = alpha;
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic write_reg(input logic reg_idx, input logic [8:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        // junk above the register width must be dropped
        pwdata  <= ($urandom & 32'hFFFF_FE00) | {23'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_IMAGE_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || items_accepted != items_pushed ||
               expected_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_outside_seed(input int w, input int h);
        if (w < MAP_SIDE && (h >= MAP_SIDE || $urandom_range(0, 1) == 1))
            push_item(OP_START, $urandom_range(w, 255), $urandom_range(0, 255), $urandom);
        else
            push_item(OP_START, $urandom_range(0, 255), $urandom_range(h, 255), $urandom);
    endtask

    // new image size, full reload of the visible area, then a mix of searches and loads
    task automatic run_phase(input logic [8:0] wr, input logic [8:0] hr);
        int w;
        int h;
        int density;
        int x;
        int y;
        int i;
        int n;
        int rx;
        int ry;
        int rw;
        int rh;
        int pick;
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, wr);
        write_reg(REG_IMAGE_HEIGHT, hr);
        w = visible_dim(wr);
        h = visible_dim(hr);
        case ($urandom_range(0, 3))
            0:       density = 0;
            1:       density = 4;
            2:       density = 15;
            default: density = 40;
        endcase
        for (y = 0; y < h; y++)
            for (x = 0; x < w; x++)
                sprite_plan[y*MAP_SIDE + x] = ($urandom_range(0, 99) < density);
        n = (w * h == 0) ? 0 : $urandom_range(0, 3);
        for (i = 0; i < n; i++)
        begin
            rx = $urandom_range(0, w - 1);
            ry = $urandom_range(0, h - 1);
            rw = $urandom_range(0, w - 1 - rx);
            rh = $urandom_range(0, h - 1 - ry);
            for (y = ry; y <= ry + rh; y++)
                for (x = rx; x <= rx + rw; x++)
                    sprite_plan[y*MAP_SIDE + x] = 1'b1;
        end
        for (y = 0; y < h; y++)
            for (x = 0; x < w; x++)
                push_item(OP_LOAD, x, y,
                          sprite_plan[y*MAP_SIDE + x] ? $urandom_range(1, 255) : 0);
        n = $urandom_range(8, 30);
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65 && (w * h == 0 || pick >= 55))
                push_outside_seed(w, h);
            else if (pick < 65)
                push_item(OP_START, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                          $urandom);
            else if (pick < 85 && w * h != 0)
                push_item(OP_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                          $urandom_range(0, 1) ? $urandom : 0);
            else
                push_item(OP_LOAD, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        logic [8:0] wr;
        logic [8:0] hr;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero width: every seed is outside; loads beyond the image are still stored
        write_reg(REG_IMAGE_WIDTH, 9'd0);
        write_reg(REG_IMAGE_HEIGHT, 9'd3);
        push_item(OP_START, 8'd0, 8'd0, 8'd0);
        push_item(OP_START, 8'd255, 8'd255, 8'd255);
        push_item(OP_LOAD, 8'd0, 8'd0, 8'd255);
        push_item(OP_LOAD, 8'd255, 8'd255, 8'd1);
        push_item(OP_LOAD, 8'd170, 8'd85, 8'd128);
        push_item(OP_LOAD, 8'd85, 8'd170, 8'd85);
        wait_idle();

        // 2x2 image: empty box, upward growth, seeds just past the right and bottom edges
        write_reg(REG_IMAGE_WIDTH, 9'd2);
        write_reg(REG_IMAGE_HEIGHT, 9'd2);
        push_item(OP_LOAD, 8'd0, 8'd0, 8'd0);
        push_item(OP_LOAD, 8'd1, 8'd0, 8'd170);
        push_item(OP_LOAD, 8'd0, 8'd1, 8'd0);
        push_item(OP_LOAD, 8'd1, 8'd1, 8'd0);
        push_item(OP_START, 8'd0, 8'd0, 8'd0);
        push_item(OP_START, 8'd1, 8'd1, 8'd0);
        push_item(OP_START, 8'd0, 8'd1, 8'd255);
        push_item(OP_START, 8'd2, 8'd0, 8'd0);
        push_item(OP_START, 8'd0, 8'd2, 8'd0);
        push_item(OP_LOAD, 8'd0, 8'd1, 8'd1);
        push_item(OP_START, 8'd0, 8'd0, 8'd0);
        push_item(OP_START, 8'd1, 8'd255, 8'd0);

        // widest and tallest images, one of them through an oversized register value
        run_phase(9'h1FF, 9'd1);
        run_phase(9'd1, 9'd256);

        while (items_pushed < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    wr = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                    hr = $urandom_range(1, 2);
                end
                1:
                begin
                    wr = $urandom_range(1, 2);
                    hr = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
                end
                2:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        wr = 0;
                        hr = $urandom_range(0, 511);
                    end
                    else
                    begin
                        wr = $urandom_range(0, 511);
                        hr = 0;
                    end
                end
                default:
                begin
                    wr = $urandom_range(1, 16);
                    hr = $urandom_range(1, 16);
                end
            endcase
            run_phase(wr, hr);
        end

        wait_idle();
        if (error_count == 0 && expected_boxes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
